FILE: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for concurrent assertions clocked on the rising edge and
// disabled while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assert a property on an explicit clock and active-low reset
`define ASSERT_AT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Assert a property on the usual clk_i / rst_ni pair
`define ASSERT_CLK(label, prop, msg) \
  `ASSERT_AT(label, clk_i, rst_ni, prop, msg)

`endif

FILE: hdl/pcqt_pkg.sv
// ----------------------------------------------------------------------------
// Pulse command queue timer package
// Register map, command codes, fixed field widths and the configuration
// selection bundle shared by the pulse command queue timer modules.
// ----------------------------------------------------------------------------
package pcqt_pkg;

  // Fixed field widths
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned PW_W       = 16;
  localparam int unsigned DEAD_W     = 32;
  localparam int unsigned CODE_W     = 3;
  localparam int unsigned FILL_OUT_W = 5;

  // Operation codes
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_SEND = 1'b1;

  // Register indexes on the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SHOOT_WIDTH     = 3'd0,
    REG_ZOOM_IN_WIDTH   = 3'd1,
    REG_ZOOM_OUT_WIDTH  = 3'd2,
    REG_EXP_MINUS_WIDTH = 3'd3,
    REG_EXP_ZERO_WIDTH  = 3'd4,
    REG_EXP_PLUS_WIDTH  = 3'd5,
    REG_PAUSE_WIDTH     = 3'd6,
    REG_DEAD_TICKS      = 3'd7
  } reg_idx_e;

  // Command codes
  typedef enum logic [CODE_W-1:0] {
    CMD_SHOOT     = 3'd0,
    CMD_ZOOM_IN   = 3'd1,
    CMD_ZOOM_OUT  = 3'd2,
    CMD_EXP_MINUS = 3'd3,
    CMD_EXP_ZERO  = 3'd4,
    CMD_EXP_PLUS  = 3'd5
  } cmd_e;

  // Register reset values
  localparam logic [PW_W-1:0]   RST_SHOOT_WIDTH     = 16'd30;
  localparam logic [PW_W-1:0]   RST_ZOOM_IN_WIDTH   = 16'd60;
  localparam logic [PW_W-1:0]   RST_ZOOM_OUT_WIDTH  = 16'd90;
  localparam logic [PW_W-1:0]   RST_EXP_MINUS_WIDTH = 16'd120;
  localparam logic [PW_W-1:0]   RST_EXP_ZERO_WIDTH  = 16'd150;
  localparam logic [PW_W-1:0]   RST_EXP_PLUS_WIDTH  = 16'd180;
  localparam logic [PW_W-1:0]   RST_PAUSE_WIDTH     = 16'd30;
  localparam logic [DEAD_W-1:0] RST_DEAD_TICKS      = 32'd100;

  // Configuration values selected for the current command
  typedef struct packed {
    logic              code_ok;
    logic [PW_W-1:0]   pulse_width;
    logic [PW_W-1:0]   pause_width;
    logic [DEAD_W-1:0] dead_ticks;
  } cfg_sel_t;

endpackage

FILE: hdl/pulse_command_queue_timer_unit.sv
// ----------------------------------------------------------------------------
// Pulse command queue timer
// Turns command items into width-coded pulses on one output line, queued in
// a ring of pulse and pause entries that tick items count down.
// ----------------------------------------------------------------------------
// One item is handled at a time, and each gives exactly one result. A tick
// that only counts down and a refused send stay in the idle state. A tick
// whose count has run out and that pops a ring entry goes through the pop
// state, as the ring memory's read port is registered. An accepted send goes
// to the push state, since the pulse and pause entries go through the ring's
// single write port one after the other. The result register lets the next
// item in while a result is taken in the same cycle. The ring needs no
// clearing after reset: only entries counted in the fill level are ever read.
module pulse_command_queue_timer_unit
  import pcqt_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned WIDTH_BITS  = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Configuration write channel
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  // Input item channel
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  operation_i,
  input  logic [CODE_W-1:0]     command_code_i,
  // Result channel
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic                  line_level_o,
  output logic                  send_accepted_o,
  output logic                  send_dropped_o,
  output logic [FILL_OUT_W-1:0] queue_fill_o
);

  localparam int unsigned ADDR_W  = $clog2(QUEUE_DEPTH);
  localparam int unsigned FILL_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned ENTRY_W = WIDTH_BITS + 1;

  localparam logic [ADDR_W-1:0] ADDR_LAST     = ADDR_W'(QUEUE_DEPTH - 1);
  localparam logic [FILL_W-1:0] FILL_PUSH_MAX = FILL_W'(QUEUE_DEPTH - 2);

  // Sequencer states
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_POP  = 2'd1;
  localparam logic [1:0] ST_PUSH = 2'd2;

  logic [1:0]            state_q, state_d;
  logic [ADDR_W-1:0]     write_slot_q, write_slot_d;
  logic [ADDR_W-1:0]     read_slot_q, read_slot_d;
  logic [FILL_W-1:0]     fill_q, fill_d;
  logic [WIDTH_BITS-1:0] remaining_q, remaining_d;
  logic                  active_high_q, active_high_d;
  logic                  line_q, line_d;
  logic [DEAD_W-1:0]     since_send_q, since_send_d;
  logic [ENTRY_W-1:0]    pend_q, pend_d;

  logic                  out_valid_q, out_valid_d;
  logic                  out_line_q;
  logic                  out_acc_q;
  logic                  out_drop_q;
  logic [FILL_OUT_W-1:0] out_fill_q;

  logic                  res_load;
  logic                  res_line;
  logic                  res_acc;
  logic                  res_drop;
  logic [FILL_W-1:0]     res_fill;

  logic [ENTRY_W-1:0]    ring_mem [QUEUE_DEPTH];
  logic                  mem_we;
  logic [ENTRY_W-1:0]    mem_wdata;
  logic                  rd_en;
  logic [ENTRY_W-1:0]    rd_data_q;

  logic                  in_fire;
  logic                  send_ok;
  logic [ADDR_W-1:0]     write_slot_inc;
  logic [ADDR_W-1:0]     read_slot_inc;
  cfg_sel_t              cfg_sel;

  pcqt_cfg_regs u_cfg_regs (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .command_code_i (command_code_i),
    .sel_o          (cfg_sel)
  );

  assign cfg_ready_o = 1'b1;

  // Hold off items while a multi-cycle item runs or a result is stuck
  assign in_stall_o = (state_q != ST_IDLE) || (out_valid_q && out_stall_i);
  assign in_fire    = in_valid_i && !in_stall_o;

  // Advance ring pointers with wrap at the queue depth
  assign write_slot_inc = (write_slot_q == ADDR_LAST) ? '0 : write_slot_q + ADDR_W'(1);
  assign read_slot_inc  = (read_slot_q == ADDR_LAST) ? '0 : read_slot_q + ADDR_W'(1);

  // Queue a send only for a known code, after the dead time, with room for two
  assign send_ok = cfg_sel.code_ok && (since_send_q > cfg_sel.dead_ticks) &&
                   (fill_q <= FILL_PUSH_MAX);

  // Sequence ticks, pops and pushes
  always_comb begin
    state_d       = state_q;
    write_slot_d  = write_slot_q;
    read_slot_d   = read_slot_q;
    fill_d        = fill_q;
    remaining_d   = remaining_q;
    active_high_d = active_high_q;
    line_d        = line_q;
    since_send_d  = since_send_q;
    pend_d        = pend_q;
    mem_we        = 1'b0;
    mem_wdata     = pend_q;
    rd_en         = 1'b0;
    res_load      = 1'b0;
    res_line      = line_q;
    res_acc       = 1'b0;
    res_drop      = 1'b0;
    res_fill      = fill_q;

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (operation_i == OP_TICK) begin
            if (!(&since_send_q)) begin
              since_send_d = since_send_q + DEAD_W'(1);
            end
            if (remaining_q != '0) begin
              remaining_d = remaining_q - WIDTH_BITS'(1);
              res_load    = 1'b1;
            end else begin
              if (active_high_q) begin
                line_d = 1'b0;
              end
              if (fill_q != '0) begin
                rd_en   = 1'b1;
                state_d = ST_POP;
              end else begin
                res_load = 1'b1;
                res_line = line_d;
              end
            end
          end else begin
            res_load = 1'b1;
            if (send_ok) begin
              mem_we       = 1'b1;
              mem_wdata    = {1'b1, WIDTH_BITS'(cfg_sel.pulse_width)};
              pend_d       = {1'b0, WIDTH_BITS'(cfg_sel.pause_width)};
              write_slot_d = write_slot_inc;
              fill_d       = fill_q + FILL_W'(2);
              since_send_d = '0;
              state_d      = ST_PUSH;
              res_acc      = 1'b1;
              res_fill     = fill_d;
            end else begin
              res_drop = 1'b1;
            end
          end
        end
      end
      ST_POP: begin
        remaining_d   = rd_data_q[WIDTH_BITS-1:0];
        active_high_d = rd_data_q[WIDTH_BITS];
        if (rd_data_q[WIDTH_BITS]) begin
          line_d = 1'b1;
        end
        read_slot_d = read_slot_inc;
        fill_d      = fill_q - FILL_W'(1);
        res_load    = 1'b1;
        res_line    = line_d;
        res_fill    = fill_d;
        state_d     = ST_IDLE;
      end
      ST_PUSH: begin
        mem_we       = 1'b1;
        mem_wdata    = pend_q;
        write_slot_d = write_slot_inc;
        state_d      = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Keep a result until it is taken
  assign out_valid_d = res_load || (out_valid_q && out_stall_i);

  // Control and queue state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      write_slot_q  <= '0;
      read_slot_q   <= '0;
      fill_q        <= '0;
      remaining_q   <= '0;
      active_high_q <= 1'b1;
      line_q        <= 1'b0;
      since_send_q  <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      write_slot_q  <= write_slot_d;
      read_slot_q   <= read_slot_d;
      fill_q        <= fill_d;
      remaining_q   <= remaining_d;
      active_high_q <= active_high_d;
      line_q        <= line_d;
      since_send_q  <= since_send_d;
      out_valid_q   <= out_valid_d;
    end
  end

  // Pending pause entry and result payload
  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
    if (res_load) begin
      out_line_q <= res_line;
      out_acc_q  <= res_acc;
      out_drop_q <= res_drop;
      out_fill_q <= FILL_OUT_W'(res_fill);
    end
  end

  // Ring memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      ring_mem[write_slot_q] <= mem_wdata;
    end
    if (rd_en) begin
      rd_data_q <= ring_mem[read_slot_q];
    end
  end

  assign out_valid_o     = out_valid_q;
  assign line_level_o    = out_line_q;
  assign send_accepted_o = out_acc_q;
  assign send_dropped_o  = out_drop_q;
  assign queue_fill_o    = out_fill_q;

endmodule

FILE: hdl/pcqt_cfg_regs.sv
// ----------------------------------------------------------------------------
// Pulse command queue timer configuration registers
// Holds the pulse widths, pause width and dead time, and selects the pulse
// width that belongs to the incoming command code.
// ----------------------------------------------------------------------------
module pcqt_cfg_regs
  import pcqt_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic [CODE_W-1:0]     command_code_i,
  output cfg_sel_t              sel_o
);

  logic [PW_W-1:0]   shoot_width_q;
  logic [PW_W-1:0]   zoom_in_width_q;
  logic [PW_W-1:0]   zoom_out_width_q;
  logic [PW_W-1:0]   exp_minus_width_q;
  logic [PW_W-1:0]   exp_zero_width_q;
  logic [PW_W-1:0]   exp_plus_width_q;
  logic [PW_W-1:0]   pause_width_q;
  logic [DEAD_W-1:0] dead_ticks_q;

  // Take a register write on each configuration transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shoot_width_q     <= RST_SHOOT_WIDTH;
      zoom_in_width_q   <= RST_ZOOM_IN_WIDTH;
      zoom_out_width_q  <= RST_ZOOM_OUT_WIDTH;
      exp_minus_width_q <= RST_EXP_MINUS_WIDTH;
      exp_zero_width_q  <= RST_EXP_ZERO_WIDTH;
      exp_plus_width_q  <= RST_EXP_PLUS_WIDTH;
      pause_width_q     <= RST_PAUSE_WIDTH;
      dead_ticks_q      <= RST_DEAD_TICKS;
    end else if (cfg_valid_i) begin
      case (reg_idx_e'(cfg_index_i))
        REG_SHOOT_WIDTH:     shoot_width_q     <= cfg_data_i[PW_W-1:0];
        REG_ZOOM_IN_WIDTH:   zoom_in_width_q   <= cfg_data_i[PW_W-1:0];
        REG_ZOOM_OUT_WIDTH:  zoom_out_width_q  <= cfg_data_i[PW_W-1:0];
        REG_EXP_MINUS_WIDTH: exp_minus_width_q <= cfg_data_i[PW_W-1:0];
        REG_EXP_ZERO_WIDTH:  exp_zero_width_q  <= cfg_data_i[PW_W-1:0];
        REG_EXP_PLUS_WIDTH:  exp_plus_width_q  <= cfg_data_i[PW_W-1:0];
        REG_PAUSE_WIDTH:     pause_width_q     <= cfg_data_i[PW_W-1:0];
        REG_DEAD_TICKS:      dead_ticks_q      <= cfg_data_i[DEAD_W-1:0];
        default: ;
      endcase
    end
  end

  // Select the pulse width for the command; unknown codes are flagged
  always_comb begin
    sel_o.code_ok     = 1'b1;
    sel_o.pulse_width = shoot_width_q;
    sel_o.pause_width = pause_width_q;
    sel_o.dead_ticks  = dead_ticks_q;
    case (cmd_e'(command_code_i))
      CMD_SHOOT:     sel_o.pulse_width = shoot_width_q;
      CMD_ZOOM_IN:   sel_o.pulse_width = zoom_in_width_q;
      CMD_ZOOM_OUT:  sel_o.pulse_width = zoom_out_width_q;
      CMD_EXP_MINUS: sel_o.pulse_width = exp_minus_width_q;
      CMD_EXP_ZERO:  sel_o.pulse_width = exp_zero_width_q;
      CMD_EXP_PLUS:  sel_o.pulse_width = exp_plus_width_q;
      default: begin
        sel_o.code_ok     = 1'b0;
        sel_o.pulse_width = '0;
      end
    endcase
  end

endmodule

FILE: hdl/pcqt_port_checker.sv
// ----------------------------------------------------------------------------
// Pulse command queue timer port checker
// Watches the result channel of the pulse command queue timer and checks
// the send flags, fill level and line level over time.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pcqt_port_checker
  import pcqt_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  out_valid_i,
  input logic                  out_stall_i,
  input logic                  line_level_i,
  input logic                  send_accepted_i,
  input logic                  send_dropped_i,
  input logic [FILL_OUT_W-1:0] queue_fill_i
);

  logic last_line_q;

  // Track the line level of the last delivered result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_line_q <= 1'b0;
    end else if (out_valid_i && !out_stall_i) begin
      last_line_q <= line_level_i;
    end
  end

  `ASSERT_CLK(a_send_flags_exclusive,
    out_valid_i |-> !(send_accepted_i && send_dropped_i),
    "send result both accepted and dropped")

  `ASSERT_CLK(a_accept_fill_two,
    (out_valid_i && send_accepted_i) |->
      ((QUEUE_DEPTH >= 32) || (queue_fill_i >= FILL_OUT_W'(2))),
    "accepted send shows fewer than two queued entries")

  `ASSERT_CLK(a_send_keeps_line,
    (out_valid_i && (send_accepted_i || send_dropped_i)) |-> (line_level_i == last_line_q),
    "send result changed the line level")

  `ASSERT_CLK(a_result_held,
    (out_valid_i && out_stall_i) |=>
      (out_valid_i && $stable(line_level_i) && $stable(send_accepted_i) &&
       $stable(send_dropped_i) && $stable(queue_fill_i)),
    "stalled result changed")

endmodule

bind pulse_command_queue_timer_unit pcqt_port_checker #(
  .QUEUE_DEPTH (QUEUE_DEPTH)
) u_port_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_i     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .line_level_i    (line_level_o),
  .send_accepted_i (send_accepted_o),
  .send_dropped_i  (send_dropped_o),
  .queue_fill_i    (queue_fill_o)
);

FILE: verif/tb_top.sv
// ----------------------------------------------------------------------------
// Pulse command queue timer testbench
// Drives tick and send items through the stall handshake with random gaps
// and back-pressure, predicts line level, send outcome and ring fill for
// every transfer, and checks each result field by field in order.
// ----------------------------------------------------------------------------
module tb_top
  import pcqt_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RING_DEPTH = 16;
  localparam int unsigned SLOT_W     = $clog2(RING_DEPTH);

  typedef struct packed {
    logic              op;
    logic [CODE_W-1:0] code;
  } cmd_item_t;

  typedef struct packed {
    logic                  line;
    logic                  accepted;
    logic                  dropped;
    logic [FILL_OUT_W-1:0] fill;
  } line_status_t;

  // DUT connections, inputs known from time zero
  logic                  clk_i          = 1'b0;
  logic                  rst_ni         = 1'b0;
  logic                  cfg_valid_i    = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i    = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i     = '0;
  logic                  in_valid_i     = 1'b0;
  logic                  in_stall_o;
  logic                  operation_i    = OP_TICK;
  logic [CODE_W-1:0]     command_code_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i    = 1'b0;
  logic                  line_level_o;
  logic                  send_accepted_o;
  logic                  send_dropped_o;
  logic [FILL_OUT_W-1:0] queue_fill_o;

  pulse_command_queue_timer_unit #(
    .QUEUE_DEPTH(RING_DEPTH),
    .WIDTH_BITS (PW_W)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .operation_i    (operation_i),
    .command_code_i (command_code_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .line_level_o   (line_level_o),
    .send_accepted_o(send_accepted_o),
    .send_dropped_o (send_dropped_o),
    .queue_fill_o   (queue_fill_o)
  );

  // Stimulus and scoreboard storage
  cmd_item_t    cmd_backlog[$];
  line_status_t status_due[$];
  int unsigned  mismatch_cnt = 0;
  bit           steady       = 1'b0;   // no gaps and no stalls while set
  bit           in_took      = 1'b0;   // input transfer at the last rising edge
  int unsigned  in_gap       = 0;
  int unsigned  stall_left   = 0;

  // Shadow of the block: configuration
  logic [PW_W-1:0]   pulse_w [6];
  logic [PW_W-1:0]   pause_w;
  logic [DEAD_W-1:0] dead_w;

  // Shadow of the block: ring and timer
  logic [PW_W-1:0]   ring_ticks [RING_DEPTH];
  logic              ring_high  [RING_DEPTH];
  logic [SLOT_W-1:0] wr_slot    = '0;
  logic [SLOT_W-1:0] rd_slot    = '0;
  logic [4:0]        fill_lvl   = '0;
  logic [PW_W-1:0]   count_left = '0;
  logic              entry_high = 1'b1;
  logic              line_lvl   = 1'b0;
  logic [DEAD_W-1:0] since_send = '0;

  initial begin
    pulse_w[0] = RST_SHOOT_WIDTH;
    pulse_w[1] = RST_ZOOM_IN_WIDTH;
    pulse_w[2] = RST_ZOOM_OUT_WIDTH;
    pulse_w[3] = RST_EXP_MINUS_WIDTH;
    pulse_w[4] = RST_EXP_ZERO_WIDTH;
    pulse_w[5] = RST_EXP_PLUS_WIDTH;
    pause_w    = RST_PAUSE_WIDTH;
    dead_w     = RST_DEAD_TICKS;
  end

  // Advance the shadow by one item and return the line status it leaves
  function automatic line_status_t advance_line(logic op, logic [CODE_W-1:0] code);
    line_status_t st;
    st = '0;
    if (op == OP_TICK) begin
      if (since_send != '1) since_send++;
      if (count_left == '0) begin
        if (entry_high) line_lvl = 1'b0;
        if (fill_lvl != '0) begin
          count_left = ring_ticks[rd_slot];
          entry_high = ring_high[rd_slot];
          if (entry_high) line_lvl = 1'b1;
          rd_slot++;
          fill_lvl--;
        end
      end else begin
        count_left--;
      end
    end else if (code > CMD_EXP_PLUS || !(since_send > dead_w) ||
                 int'(fill_lvl) + 2 > RING_DEPTH) begin
      st.dropped = 1'b1;
    end else begin
      ring_ticks[wr_slot] = pulse_w[code];
      ring_high[wr_slot]  = 1'b1;
      wr_slot++;
      ring_ticks[wr_slot] = pause_w;
      ring_high[wr_slot]  = 1'b0;
      wr_slot++;
      fill_lvl    = fill_lvl + 5'd2;
      since_send  = '0;
      st.accepted = 1'b1;
    end
    st.line = line_lvl;
    st.fill = fill_lvl;
    return st;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      mismatch_cnt++;
      if (mismatch_cnt <= 50)
        $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Monitor: predict on every input transfer, check every result transfer
  always @(posedge clk_i) begin
    line_status_t want;
    in_took = rst_ni && in_valid_i && !in_stall_o;
    if (in_took) status_due.push_back(advance_line(operation_i, command_code_i));
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (status_due.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 50)
          $display("%0t ns: result with none expected, actual line %0b fill %0d",
                   $time, line_level_o, queue_fill_o);
      end else begin
        want = status_due.pop_front();
        check_field("line_level", want.line, line_level_o);
        check_field("send_accepted", want.accepted, send_accepted_o);
        check_field("send_dropped", want.dropped, send_dropped_o);
        check_field("queue_fill", want.fill, queue_fill_o);
      end
    end
  end

  // Driver: feed items from the backlog, hold while stalled, insert gaps
  always @(negedge clk_i) begin
    cmd_item_t it;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (in_valid_i && !in_took) begin
      // hold the stalled transfer
    end else if (in_gap > 0) begin
      in_valid_i <= 1'b0;
      in_gap--;
    end else if (cmd_backlog.size() > 0) begin
      it = cmd_backlog.pop_front();
      in_valid_i     <= 1'b1;
      operation_i    <= it.op;
      command_code_i <= it.code;
      in_gap = steady ? 0 : pick_gap();
    end else begin
      in_valid_i <= 1'b0;
    end
  end

  // Receiver back-pressure
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left--;
    end else begin
      out_stall_i <= 1'b0;
      if (!steady && $urandom_range(0, 3) == 0) stall_left = pick_gap();
    end
  end

  // Write one register and mirror it in the shadow
  task automatic program_reg(reg_idx_e idx, logic [CFG_DATA_W-1:0] value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_PAUSE_WIDTH: pause_w = value[PW_W-1:0];
      REG_DEAD_TICKS:  dead_w  = value;
      default:         pulse_w[idx] = value[PW_W-1:0];
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Random widths with junk in the unused upper bits
  task automatic program_random(int unsigned max_w, int unsigned max_pause,
                                int unsigned max_dead);
    reg_idx_e idx;
    idx = REG_SHOOT_WIDTH;
    repeat (6) begin
      program_reg(idx, {16'($urandom()), 16'($urandom_range(1, max_w))});
      idx = idx.next();
    end
    program_reg(REG_PAUSE_WIDTH, {16'($urandom()), 16'($urandom_range(0, max_pause))});
    program_reg(REG_DEAD_TICKS, 32'($urandom_range(0, max_dead)));
  endtask

  task automatic add_item(logic op, logic [CODE_W-1:0] code);
    cmd_backlog.push_back('{op: op, code: code});
  endtask

  // Wait until every queued item has been sent and every result taken
  task automatic wait_drained();
    while (cmd_backlog.size() > 0 || in_valid_i || status_due.size() > 0)
      @(posedge clk_i);
  endtask

  // Sends followed by short runs of ticks, some lone ticks
  task automatic run_random(int unsigned n, int unsigned send_pct);
    int unsigned made;
    int unsigned tail;
    made = 0;
    while (made < n) begin
      if ($urandom_range(0, 99) < send_pct) begin
        if ($urandom_range(0, 99) < 92)
          add_item(OP_SEND, CODE_W'($urandom_range(0, 5)));
        else
          add_item(OP_SEND, CODE_W'($urandom_range(6, 7)));
        tail = $urandom_range(0, 5);
        repeat (tail) add_item(OP_TICK, '0);
        made += tail + 1;
      end else begin
        add_item(OP_TICK, '0);
        made++;
      end
    end
  endtask

  // Run limit
  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

  // Stimulus sequence
  initial begin
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: send inside dead time, undefined code
    add_item(OP_SEND, CMD_SHOOT);
    add_item(OP_TICK, '0);
    add_item(OP_SEND, 3'd7);
    wait_drained();

    // Zero shoot width, no pause, no dead time
    program_reg(REG_SHOOT_WIDTH, 32'hABCD_0000);
    program_reg(REG_ZOOM_IN_WIDTH, 32'd20);
    program_reg(REG_ZOOM_OUT_WIDTH, 32'd1);
    program_reg(REG_EXP_MINUS_WIDTH, 32'd2);
    program_reg(REG_EXP_ZERO_WIDTH, 32'd3);
    program_reg(REG_EXP_PLUS_WIDTH, 32'd4);
    program_reg(REG_PAUSE_WIDTH, 32'd0);
    program_reg(REG_DEAD_TICKS, 32'd0);
    add_item(OP_SEND, CMD_SHOOT);
    repeat (3) add_item(OP_TICK, '0);
    add_item(OP_SEND, CMD_ZOOM_IN);
    add_item(OP_SEND, CMD_ZOOM_OUT);         // dead time not elapsed
    add_item(OP_TICK, '0);
    for (int i = 0; i < 7; i++) begin        // fill the ring behind a long pulse
      add_item(OP_SEND, CODE_W'(i % 6));
      add_item(OP_TICK, '0);
    end
    add_item(OP_SEND, CMD_EXP_PLUS);         // no room for two entries
    add_item(OP_TICK, '0);
    add_item(OP_SEND, 3'd6);
    wait_drained();

    // Short pulses with idling
    program_random(6, 3, 3);
    run_random(120, 35);
    wait_drained();

    // Same range without idling
    steady = 1'b1;
    program_random(6, 3, 3);
    run_random(100, 35);
    wait_drained();
    steady = 1'b0;

    // Longer pulses, with a full drain halfway
    program_random(40, 20, 30);
    run_random(60, 30);
    wait_drained();
    run_random(60, 30);
    wait_drained();

    // Send-heavy to keep the ring full
    program_random(3, 1, 0);
    run_random(120, 70);
    wait_drained();

    // No send can pass the dead time
    program_random(4, 4, 4);
    program_reg(REG_DEAD_TICKS, 32'hFFFF_FFFF);
    run_random(80, 40);
    wait_drained();

    // Widest pulse and pause
    program_random(4, 4, 0);
    program_reg(REG_ZOOM_IN_WIDTH, 32'hFFFF_FFFF);
    program_reg(REG_PAUSE_WIDTH, 32'hFFFF_FFFF);
    program_reg(REG_DEAD_TICKS, 32'd0);
    add_item(OP_TICK, '0);
    add_item(OP_SEND, CMD_ZOOM_IN);
    run_random(100, 40);
    wait_drained();

    repeat (20) @(posedge clk_i);
    if (mismatch_cnt == 0 && status_due.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
